/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication or plain property
`define CHECK_NOW(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property on the following cycle
`define CHECK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);

`endif

/* design/hkd_pkg.sv */
// ----------------------------------------------------------------------------
// hkd_pkg
// Shared types and constants of the keyboard report event converter.
// ----------------------------------------------------------------------------
package hkd_pkg;

  localparam int MAX_SLOTS = 6;
  localparam int CODE_W    = 8;
  localparam int KEY_CODES = 1 << CODE_W;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);

  // one queued operation against the held-key map
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              is_press;
    logic              last;
  } op_t;

endpackage

/* design/hkd_front.sv */
// ----------------------------------------------------------------------------
// hkd_front
// Accepts a report, classifies release and press candidates, issues ops.
// ----------------------------------------------------------------------------
module hkd_front
  import hkd_pkg::*;
#(
  parameter int KEY_SLOTS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CODE_W-1:0] slots [MAX_SLOTS],
  output op_t               op,
  output logic              push,
  input  logic              q_full
);

  localparam int N_OPS = 2 * KEY_SLOTS;
  localparam int SEL_W = $clog2(N_OPS);

  logic [CODE_W-1:0] prev  [KEY_SLOTS];
  logic [CODE_W-1:0] codes [N_OPS];
  logic [N_OPS-1:0]  mask;
  logic [N_OPS-1:0]  mask_new;
  logic [N_OPS-1:0]  mask_clr;
  logic [SEL_W-1:0]  sel;
  logic              accept;

  always_comb begin
    sel = '0;
    for (int i = N_OPS - 1; i >= 0; i--) begin
      if (mask[i]) sel = SEL_W'(i);
    end
  end

  // drop the lowest pending bit once its op is pushed
  assign mask_clr = mask & (mask - N_OPS'(1));

  assign op.code     = codes[sel];
  assign op.is_press = (sel >= SEL_W'(KEY_SLOTS));
  assign op.last     = (mask_clr == '0);

  assign push     = (|mask) && !q_full;
  assign in_stall = (|mask) && !(push && op.last);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    mask_new = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      logic found;
      found = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (slots[j] == prev[i]) found = 1'b1;
      end
      mask_new[i]             = (prev[i] != '0) && !found;
      mask_new[KEY_SLOTS + i] = (slots[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) prev[i] <= '0;
    end else begin
      if (accept) begin
        mask <= mask_new;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          codes[i]             <= prev[i];
          codes[KEY_SLOTS + i] <= slots[i];
          prev[i]              <= slots[i];
        end
      end else if (push) begin
        mask <= mask_clr;
      end
    end
  end

endmodule

/* design/hkd_queue.sv */
// ----------------------------------------------------------------------------
// hkd_queue
// Short FIFO of ops between the classifier and the map sequencer.
// ----------------------------------------------------------------------------
module hkd_queue
  import hkd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  op_t  wr_op,
  input  logic push,
  output logic full,
  output op_t  head,
  output logic head_valid,
  input  logic pop
);

  op_t             slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full       = (count == (Q_AW + 1)'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= wr_op;
        wr_ptr        <= wr_ptr + Q_AW'(1);
      end
      if (pop) rd_ptr <= rd_ptr + Q_AW'(1);
      if (push && !pop) count <= count + (Q_AW + 1)'(1);
      else if (pop && !push) count <= count - (Q_AW + 1)'(1);
    end
  end

endmodule

/* design/hkd_back.sv */
// ----------------------------------------------------------------------------
// hkd_back
// Runs ops against the held-key map and emits events, marking the last.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hkd_back
  import hkd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  op_t               head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] event_code,
  output logic              is_press,
  output logic              last_event
);

  logic                 map_mem [KEY_CODES];
  logic [KEY_CODES-1:0] written;

  logic              s1_valid;
  op_t               s1_op;
  logic              s1_mem;
  logic              s1_vbit;
  logic              s1_fwd_hit;
  logic              s1_fwd_val;

  logic              hold_valid;
  logic              hold_final;
  logic [CODE_W-1:0] hold_code;
  logic              hold_press;

  logic              out_free;
  logic              out_load;
  logic              s1_retire;
  logic              hold_flush;
  logic              held;
  logic              ev_valid;
  logic              ev_press;
  logic [CODE_W-1:0] ev_code;
  logic              wr_en;
  logic              wr_val;

  assign out_free   = !out_valid || !out_stall;
  // a final event in hold must leave before the next op runs
  assign s1_retire  = s1_valid && out_free && !(hold_valid && hold_final);
  assign hold_flush = hold_valid && hold_final && out_free;
  assign pop        = head_valid && (!s1_valid || s1_retire);
  assign held       = s1_fwd_hit ? s1_fwd_val : (s1_vbit & s1_mem);
  assign out_load   = hold_flush ||
                      (s1_retire && hold_valid && (ev_valid || s1_op.last));

  always_comb begin
    ev_code  = s1_op.code;
    wr_val   = 1'b0;
    if (s1_op.is_press) begin
      ev_valid = !held;
      ev_press = 1'b1;
      wr_en    = s1_retire && !held;
      wr_val   = 1'b1;
    end else begin
      ev_valid = 1'b1;
      ev_press = 1'b0;
      wr_en    = s1_retire;
      if (!held) ev_code = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[s1_op.code] <= wr_val;
    if (pop) s1_mem <= map_mem[head.code];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (wr_en) written[s1_op.code] <= 1'b1;
      if (pop) s1_valid <= 1'b1;
      else if (s1_retire) s1_valid <= 1'b0;
    end
  end

  // forward a write landing on the same edge as the read
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op      <= head;
      s1_vbit    <= written[head.code];
      s1_fwd_hit <= wr_en && (s1_op.code == head.code);
      s1_fwd_val <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_final <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (hold_flush) begin
        event_code <= hold_code;
        is_press   <= hold_press;
        last_event <= 1'b1;
        hold_valid <= 1'b0;
      end else if (s1_retire) begin
        if (ev_valid) begin
          if (hold_valid) begin
            event_code <= hold_code;
            is_press   <= hold_press;
            last_event <= 1'b0;
          end
          hold_valid <= 1'b1;
          hold_final <= s1_op.last;
          hold_code  <= ev_code;
          hold_press <= ev_press;
        end else if (s1_op.last && hold_valid) begin
          event_code <= hold_code;
          is_press   <= hold_press;
          last_event <= 1'b1;
          hold_valid <= 1'b0;
        end
      end
    end
  end

  `CHECK_NOW(a_final_blocks_retire, (hold_valid && hold_final) |-> !s1_retire, "op ran past final")
  `CHECK_NOW(a_release_emits, (s1_valid && !s1_op.is_press) |-> ev_valid, "release lost")
  `CHECK_NEXT(a_flush_empties_hold, hold_flush, !hold_valid, "hold kept after final word")

endmodule

/* design/hid_report_key_event_diff.sv */
// ----------------------------------------------------------------------------
// hid_report_key_event_diff
// Turns keyboard reports of key code slots into key press and release words.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with key_slot_0..5; only the first
// KEY_SLOTS slots count. Output channel: out_valid/out_stall carrying
// event_code, is_press and last_event, one event per word.
// Each report gives its releases in slot order, then its presses, and the
// last word of the report has last_event set; a report with no change gives
// no word. The classifier issues one op per cycle while the queue is not full
// (releases plus nonzero slots of the new report) and holds the input until
// the report's last op is pushed; the map sequencer retires one op per cycle
// while the output is free and no final word waits in hold, then sends the
// report's final word. The map read is a registered memory port with
// same-edge forwarding, so back-to-back ops on one code see each other.
// Reset (rst, synchronous) empties the queue, zeroes the previous report and
// clears all 256 map entries at once through per-entry valid bits.
// A stall on the output holds the current word; the op queue lets the input
// keep taking reports until it fills.
// ----------------------------------------------------------------------------
module hid_report_key_event_diff
  import hkd_pkg::*;
#(
  parameter int KEY_SLOTS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CODE_W-1:0] key_slot_0,
  input  logic [CODE_W-1:0] key_slot_1,
  input  logic [CODE_W-1:0] key_slot_2,
  input  logic [CODE_W-1:0] key_slot_3,
  input  logic [CODE_W-1:0] key_slot_4,
  input  logic [CODE_W-1:0] key_slot_5,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] event_code,
  output logic              is_press,
  output logic              last_event
);

  logic [CODE_W-1:0] slots [MAX_SLOTS];
  op_t               front_op;
  op_t               head;
  logic              push;
  logic              q_full;
  logic              head_valid;
  logic              pop;

  assign slots[0] = key_slot_0;
  assign slots[1] = key_slot_1;
  assign slots[2] = key_slot_2;
  assign slots[3] = key_slot_3;
  assign slots[4] = key_slot_4;
  assign slots[5] = key_slot_5;

  hkd_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .slots    (slots),
    .op       (front_op),
    .push     (push),
    .q_full   (q_full)
  );

  hkd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_op      (front_op),
    .push       (push),
    .full       (q_full),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  hkd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_code (event_code),
    .is_press   (is_press),
    .last_event (last_event)
  );

endmodule
